FILE: rtl/prefix_price_table_defines.svh
// ============================================================================
// prefix_price_table_defines.svh
// Assertion macros for the prefix price table RTL.
// ============================================================================
`ifndef PREFIX_PRICE_TABLE_DEFINES_SVH
`define PREFIX_PRICE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset
`define PPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define PPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/ppt_pkg.sv
// ============================================================================
// ppt_pkg
// Types, status codes and digit helpers for the prefix price table.
// ============================================================================
package ppt_pkg;

    localparam int NUM_NIBBLES = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_NOT_CHEAPER = 2'd1,
        ST_FULL        = 2'd2,
        ST_INVALID     = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    // One stored table entry
    typedef struct packed {
        logic [63:0] digits;
        logic [4:0]  len;
        logic [7:0]  oper;
        logic [23:0] price;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Keep the top n nibbles of a digit word
    function automatic logic [63:0] top_mask(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < NUM_NIBBLES; i++) begin
            if (i < int'(n)) begin
                m[63 - 4*i -: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    // True when n is nonzero and every used nibble is a decimal digit
    function automatic logic digits_ok(input logic [63:0] d, input logic [4:0] n);
        logic ok;
        ok = (n != 5'd0);
        for (int i = 0; i < NUM_NIBBLES; i++) begin
            if (i < int'(n) && d[63 - 4*i -: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

FILE: rtl/ppt_if.sv
// ============================================================================
// ppt_if
// Valid/ready channels carrying request and result words.
// ============================================================================

// Request channel: insert or lookup word
interface ppt_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] digits;
    logic [4:0]  digit_count;
    logic [7:0]  operator_id;
    logic [23:0] price;

    modport source (output valid, output opcode, output digits, output digit_count,
                    output operator_id, output price, input ready);
    modport sink   (input valid, input opcode, input digits, input digit_count,
                    input operator_id, input price, output ready);
endinterface

// Result channel: one word per request
interface ppt_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  match_operator;
    logic [23:0] match_price;
    logic [4:0]  match_length;
    logic [1:0]  status;

    modport source (output valid, output found, output match_operator,
                    output match_price, output match_length, output status,
                    input ready);
    modport sink   (input valid, input found, input match_operator,
                    input match_price, input match_length, input status,
                    output ready);
endinterface

FILE: rtl/ppt_ram.sv
// ============================================================================
// ppt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/prefix_price_table.sv
// ============================================================================
// prefix_price_table
// Table of decimal dialing prefixes with operator and price, longest match.
// ============================================================================
// Usage:
//   i_in carries one request word: opcode 0 inserts a prefix with its
//   operator and price, opcode 1 looks up a phone number. o_out returns
//   exactly one result word per request, in request order.
//   Each request scans the stored entries, one RAM read per cycle, before
//   its result goes to the output register; an insert that hits an
//   existing prefix stops early, and invalid digits skip the scan.
//   The block works on one request at a time; i_in.ready is high in idle.
//   The result sits in an output register, so a new request is taken
//   while an earlier result waits; a stalled receiver holds the next
//   result in the sequencer until the output register frees up.
//   Synchronous reset empties the table (fill count to zero) at once;
//   the entry RAM needs no clearing since only filled entries are read.
// ============================================================================
`include "prefix_price_table_defines.svh"

module prefix_price_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_DIGITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppt_in_if.sink      i_in,
    ppt_out_if.source   o_out
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    // Sequencer state
    ppt_pkg::t_state r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_idx, n_idx;
    logic            r_rd_valid, n_rd_valid;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;

    // Request held during the scan
    logic            r_op;
    logic [63:0]     r_digits;
    logic [4:0]      r_len;
    logic [7:0]      r_oid;
    logic [23:0]     r_price;
    logic            r_bad;

    // Best match so far
    logic            r_hit, n_hit;
    logic [4:0]      r_best_len, n_best_len;
    logic [7:0]      r_best_op, n_best_op;
    logic [23:0]     r_best_pr, n_best_pr;

    // Finished result waiting for the output register
    logic            r_res_found, n_res_found;
    logic [7:0]      r_res_op, n_res_op;
    logic [23:0]     r_res_pr, n_res_pr;
    logic [4:0]      r_res_len, n_res_len;
    ppt_pkg::t_status r_res_status, n_res_status;

    // Output register
    logic            r_out_valid, n_out_valid;
    logic            out_load;
    logic            r_out_found;
    logic [7:0]      r_out_op;
    logic [23:0]     r_out_pr;
    logic [4:0]      r_out_len;
    ppt_pkg::t_status r_out_status;

    // Request decode
    logic            accept;
    logic [4:0]      in_len;
    logic            in_ok;

    // Entry RAM
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    ppt_pkg::t_entry             ram_wdata;
    logic [ppt_pkg::ENTRY_W-1:0] ram_rdata;
    ppt_pkg::t_entry             ent;
    logic                        ent_same;
    logic                        ent_hit;
    logic                        is_full;

    assign i_in.ready = (r_state == ppt_pkg::S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Saturate the digit count and check the used nibbles
    assign in_len = (i_in.digit_count > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : i_in.digit_count;
    assign in_ok  = ppt_pkg::digits_ok(i_in.digits, in_len);

    ppt_ram #(
        .WIDTH (ppt_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Compare the entry read last cycle against the request
    assign ent      = ppt_pkg::t_entry'(ram_rdata);
    assign ent_same = (ent.len == r_len) && (ent.digits == r_digits);
    assign ent_hit  = (ent.len != 5'd0) && (ent.len <= r_len)
                   && ((r_digits & ppt_pkg::top_mask(ent.len)) == ent.digits)
                   && (ent.len > r_best_len);
    assign is_full  = (r_fill == FW'(TABLE_DEPTH));

    // Both write cases store the request itself
    assign ram_wdata = '{digits: r_digits, len: r_len, oper: r_oid, price: r_price};
    assign ram_raddr = r_idx[AW-1:0];

    // Next state, scan and result
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_rd_valid   = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_hit        = r_hit;
        n_best_len   = r_best_len;
        n_best_op    = r_best_op;
        n_best_pr    = r_best_pr;
        n_res_found  = r_res_found;
        n_res_op     = r_res_op;
        n_res_pr     = r_res_pr;
        n_res_len    = r_res_len;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = r_rd_idx;
        out_load     = 1'b0;

        case (r_state)
            ppt_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state    = ppt_pkg::S_SCAN;
                    n_idx      = '0;
                    n_hit      = 1'b0;
                    n_best_len = '0;
                    n_best_op  = '0;
                    n_best_pr  = '0;
                end
            end
            ppt_pkg::S_SCAN: begin
                if (r_bad) begin
                    n_state      = ppt_pkg::S_RESP;
                    n_res_found  = 1'b0;
                    n_res_op     = '0;
                    n_res_pr     = '0;
                    n_res_len    = '0;
                    n_res_status = ppt_pkg::ST_INVALID;
                end else begin
                    // Issue the next read while entries remain
                    if (r_idx < r_fill) begin
                        n_rd_valid = 1'b1;
                        n_rd_idx   = r_idx[AW-1:0];
                        n_idx      = r_idx + FW'(1);
                    end
                    if (r_rd_valid) begin
                        if (!r_op) begin
                            // Existing prefix: replace only if strictly cheaper
                            if (ent_same) begin
                                n_state      = ppt_pkg::S_RESP;
                                n_rd_valid   = 1'b0;
                                n_res_found  = 1'b0;
                                n_res_op     = '0;
                                n_res_pr     = '0;
                                n_res_len    = '0;
                                if (r_price < ent.price) begin
                                    ram_we       = 1'b1;
                                    ram_waddr    = r_rd_idx;
                                    n_res_status = ppt_pkg::ST_DONE;
                                end else begin
                                    n_res_status = ppt_pkg::ST_NOT_CHEAPER;
                                end
                            end
                        end else if (ent_hit) begin
                            n_hit      = 1'b1;
                            n_best_len = ent.len;
                            n_best_op  = ent.oper;
                            n_best_pr  = ent.price;
                        end
                    end
                    // End of table reached with no read in flight
                    if (!r_rd_valid && (r_idx == r_fill)) begin
                        n_state = ppt_pkg::S_RESP;
                        if (!r_op) begin
                            n_res_found = 1'b0;
                            n_res_op    = '0;
                            n_res_pr    = '0;
                            n_res_len   = '0;
                            if (is_full) begin
                                n_res_status = ppt_pkg::ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                ram_waddr    = r_fill[AW-1:0];
                                n_fill       = r_fill + FW'(1);
                                n_res_status = ppt_pkg::ST_DONE;
                            end
                        end else begin
                            n_res_found  = r_hit;
                            n_res_op     = r_best_op;
                            n_res_pr     = r_best_pr;
                            n_res_len    = r_best_len;
                            n_res_status = ppt_pkg::ST_DONE;
                        end
                    end
                end
            end
            ppt_pkg::S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ppt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppt_pkg::S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !o_out.ready);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppt_pkg::S_IDLE;
            r_fill      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_hit        <= n_hit;
        r_best_len   <= n_best_len;
        r_best_op    <= n_best_op;
        r_best_pr    <= n_best_pr;
        r_res_found  <= n_res_found;
        r_res_op     <= n_res_op;
        r_res_pr     <= n_res_pr;
        r_res_len    <= n_res_len;
        r_res_status <= n_res_status;
        // Capture the request word, digits trimmed to the used nibbles
        if (accept) begin
            r_op     <= i_in.opcode;
            r_digits <= i_in.digits & ppt_pkg::top_mask(in_len);
            r_len    <= in_len;
            r_oid    <= i_in.operator_id;
            r_price  <= i_in.price;
            r_bad    <= !in_ok;
        end
        // Load the output register
        if (out_load) begin
            r_out_found  <= r_res_found;
            r_out_op     <= r_res_op;
            r_out_pr     <= r_res_pr;
            r_out_len    <= r_res_len;
            r_out_status <= r_res_status;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_out_found;
    assign o_out.match_operator = r_out_op;
    assign o_out.match_price    = r_out_pr;
    assign o_out.match_length   = r_out_len;
    assign o_out.status         = r_out_status;

    // Checks
    `PPT_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(TABLE_DEPTH), "fill count above table depth")
    `PPT_ASSERT_IMPL(a_read_in_scan, i_clk, i_rst_n, r_rd_valid, r_state == ppt_pkg::S_SCAN, "read in flight outside scan")
    `PPT_ASSERT_IMPL(a_write_in_scan, i_clk, i_rst_n, ram_we, (r_state == ppt_pkg::S_SCAN) && !r_bad, "table write outside a valid scan")
    `PPT_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, accept, (r_state == ppt_pkg::S_SCAN) && (r_idx == '0), "accepted word did not start a scan")
    `PPT_ASSERT_NEXT(a_fill_steady, i_clk, i_rst_n, r_state != ppt_pkg::S_SCAN, r_fill == $past(r_fill), "fill count moved outside scan")

endmodule

FILE: tb/prefix_price_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_price_table_tb
// Self-checking bench for the prefix price table. A short directed table
// covers empty-table lookups, invalid digits, digit-count saturation, the
// not-cheaper and cheaper update paths and all-nines / all-zeros prefixes.
// Random traffic follows: inserts and lookups built from a small digit
// alphabet so that prefixes collide, nest and fill the table, plus noise
// and broken words. Each result word is checked against a typed answer or a
// bench-side copy of the table, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module prefix_price_table_tb;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_DIGITS   = 16;
    localparam int RANDOM_ITEMS = 1878;

    localparam bit OP_INSERT = 1'b0;
    localparam bit OP_LOOKUP = 1'b1;

    typedef struct {
        bit          opcode;
        logic [63:0] digits;
        logic [4:0]  digit_count;
        logic [7:0]  operator_id;
        logic [23:0] price;
    } t_request;

    typedef struct {
        bit               found;
        logic [7:0]       oper;
        logic [23:0]      price;
        logic [4:0]       len;
        ppt_pkg::t_status status;
    } t_answer;

    typedef struct {
        t_request rq;
        bit       typed;
        t_answer  ans;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    ppt_in_if  req_if ();
    ppt_out_if ans_if ();

    prefix_price_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (ans_if)
    );

    // Bench copy of the prefix table
    logic [63:0] tab_digits [TABLE_DEPTH];
    logic [4:0]  tab_len    [TABLE_DEPTH];
    logic [7:0]  tab_oper   [TABLE_DEPTH];
    logic [23:0] tab_price  [TABLE_DEPTH];
    int          tab_fill = 0;

    t_answer   pending_answers [$];
    t_stim_row directed_rows [$];
    int        fail_count    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        #50ms;
        $display("[prefix_price_table] ERROR");
        $finish;
    end

    // Keep the top n nibbles, n in 1..16
    function automatic logic [63:0] nibble_mask(input int n);
        return ~64'h0 << (64 - 4 * n);
    endfunction

    // Apply one word to the bench table and return the result it yields
    function automatic t_answer table_answer(input t_request rq);
        t_answer     a;
        int          n;
        int          slot;
        bit          ok;
        logic [63:0] key;
        a.found  = 1'b0;
        a.oper   = '0;
        a.price  = '0;
        a.len    = '0;
        a.status = ppt_pkg::ST_DONE;
        n = (rq.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(rq.digit_count);
        ok = (n != 0);
        for (int i = 0; i < n; i++) begin
            if (rq.digits[63 - 4 * i -: 4] > 4'd9) ok = 1'b0;
        end
        if (!ok) begin
            a.status = ppt_pkg::ST_INVALID;
            return a;
        end
        key = rq.digits & nibble_mask(n);
        if (rq.opcode == OP_INSERT) begin
            slot = -1;
            for (int i = 0; i < tab_fill; i++) begin
                if (tab_len[i] == n && tab_digits[i] == key) begin
                    slot = i;
                    break;
                end
            end
            if (slot >= 0) begin
                // Replace only on a strictly lower price
                if (rq.price < tab_price[slot]) begin
                    tab_oper[slot]  = rq.operator_id;
                    tab_price[slot] = rq.price;
                end else begin
                    a.status = ppt_pkg::ST_NOT_CHEAPER;
                end
            end else if (tab_fill >= TABLE_DEPTH) begin
                a.status = ppt_pkg::ST_FULL;
            end else begin
                tab_digits[tab_fill] = key;
                tab_len[tab_fill]    = 5'(n);
                tab_oper[tab_fill]   = rq.operator_id;
                tab_price[tab_fill]  = rq.price;
                tab_fill++;
            end
        end else begin
            // Longest stored prefix wins; first one found on a tie
            for (int i = 0; i < tab_fill; i++) begin
                if (tab_len[i] <= n && tab_len[i] > a.len &&
                    (key & nibble_mask(tab_len[i])) == tab_digits[i]) begin
                    a.found = 1'b1;
                    a.len   = tab_len[i];
                    a.oper  = tab_oper[i];
                    a.price = tab_price[i];
                end
            end
        end
        return a;
    endfunction

    // Mostly a small alphabet so that prefixes collide and nest
    function automatic logic [3:0] pick_digit();
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 9));
        return 4'($urandom_range(0, 3));
    endfunction

    // Build one random word: noise, broken words, inserts and lookups
    function automatic t_request random_request();
        t_request rq;
        int       kind;
        int       len;
        int       first;
        int       src;
        rq.digits      = {$urandom, $urandom};
        rq.operator_id = 8'($urandom_range(0, 255));
        rq.price       = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 255));
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            rq.opcode      = 1'($urandom_range(0, 1));
            rq.digit_count = 5'($urandom_range(0, 31));
            return rq;
        end
        rq.opcode = (kind < 50) ? OP_INSERT : OP_LOOKUP;
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        first = 0;
        src   = -1;
        // Reuse a stored prefix: a price update or a number that extends it
        if (tab_fill > 0 &&
            $urandom_range(0, 99) < ((rq.opcode == OP_INSERT) ? 30 : 75)) begin
            src = $urandom_range(0, tab_fill - 1);
            first = tab_len[src];
            for (int i = 0; i < first; i++) begin
                rq.digits[63 - 4 * i -: 4] = tab_digits[src][63 - 4 * i -: 4];
            end
            if (rq.opcode == OP_INSERT) begin
                len = first;
            end else begin
                len = first + $urandom_range(0, 4);
                if ($urandom_range(0, 5) == 0 || len > 16) len = 16;
            end
        end
        for (int i = first; i < len; i++) rq.digits[63 - 4 * i -: 4] = pick_digit();
        rq.digit_count = 5'(len);
        if (len == 16 && $urandom_range(0, 3) == 0) rq.digit_count = 5'($urandom_range(17, 31));
        // Break the word: empty count or a non-decimal used digit
        if (kind >= 95) begin
            if ($urandom_range(0, 3) == 0) begin
                rq.digit_count = '0;
            end else begin
                rq.digits[63 - 4 * $urandom_range(0, len - 1) -: 4] = 4'($urandom_range(10, 15));
            end
        end
        return rq;
    endfunction

    // Queue one directed row, typed answer optional
    task automatic add_row(input bit op, input logic [63:0] d, input logic [4:0] cnt,
                           input logic [7:0] oper, input logic [23:0] pr, input bit typed,
                           input bit f, input logic [7:0] mo, input logic [23:0] mp,
                           input logic [4:0] ml, input ppt_pkg::t_status st);
        t_stim_row r;
        r.rq.opcode      = op;
        r.rq.digits      = d;
        r.rq.digit_count = cnt;
        r.rq.operator_id = oper;
        r.rq.price       = pr;
        r.typed          = typed;
        r.ans.found      = f;
        r.ans.oper       = mo;
        r.ans.price      = mp;
        r.ans.len        = ml;
        r.ans.status     = st;
        directed_rows.push_back(r);
    endtask

    // Drive one word, hold it until accepted, then log its expected result
    task automatic send_request(input t_request rq, input bit typed, input t_answer typed_ans);
        t_answer model_ans;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= rq.opcode;
        req_if.digits      <= rq.digits;
        req_if.digit_count <= rq.digit_count;
        req_if.operator_id <= rq.operator_id;
        req_if.price       <= rq.price;
        do @(posedge i_clk); while (!req_if.ready);
        model_ans = table_answer(rq);
        pending_answers.push_back(typed ? typed_ans : model_ans);
    endtask

    // Check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin : check_answers
        t_answer want;
        if (i_rst_n && ans_if.valid && ans_if.ready) begin
            if (pending_answers.size() == 0) begin
                if (fail_count < 10) $display("unexpected result word, status=%0d", ans_if.status);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (ans_if.found !== want.found || ans_if.match_operator !== want.oper ||
                    ans_if.match_price !== want.price || ans_if.match_length !== want.len ||
                    ans_if.status !== want.status) begin
                    if (fail_count < 10) begin
                        $display("mismatch: exp found=%0d op=%0d price=%h len=%0d st=%0d",
                                 want.found, want.oper, want.price, want.len, want.status);
                        $display("          got found=%0d op=%0d price=%h len=%0d st=%0d",
                                 ans_if.found, ans_if.match_operator, ans_if.match_price,
                                 ans_if.match_length, ans_if.status);
                    end
                    fail_count++;
                end
            end
        end
        ans_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Main sequence
    initial begin : run_traffic
        t_answer no_ans;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.opcode      <= OP_INSERT;
        req_if.digits      <= '0;
        req_if.digit_count <= '0;
        req_if.operator_id <= '0;
        req_if.price       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, invalid words, extremes, update paths
        add_row(OP_LOOKUP, 64'h1234_5678_9012_3456, 5'd16, 8'h00, 24'h0,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_INSERT, 64'h1000_0000_0000_0000, 5'd0, 8'h11, 24'h5,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_INVALID);
        add_row(OP_INSERT, 64'h1A00_0000_0000_0000, 5'd2, 8'h11, 24'h5,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_INVALID);
        add_row(OP_LOOKUP, 64'h999F_0000_0000_0000, 5'd4, 8'h00, 24'h0,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_INVALID);
        add_row(OP_INSERT, 64'h1000_0000_0000_0000, 5'd1, 8'hFF, 24'hFFFFFF,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_INSERT, 64'h1200_0000_0000_0000, 5'd2, 8'h00, 24'h0,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_INSERT, 64'h1000_0000_0000_0000, 5'd1, 8'h01, 24'hFFFFFF,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_NOT_CHEAPER);
        add_row(OP_INSERT, 64'h1FFF_FFFF_FFFF_FFFF, 5'd1, 8'h05, 24'h010000,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h1234_5678_9012_3456, 5'd16, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h1900_0000_0000_0000, 5'd2, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h1200_0000_0000_0000, 5'd1, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_INSERT, 64'h9999_9999_9999_9999, 5'd16, 8'hFF, 24'hFFFFFF,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h9999_9999_9999_9999, 5'd31, 8'h00, 24'h0,
                1, 1, 8'hFF, 24'hFFFFFF, 5'd16, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h9999_9999_9999_9990, 5'd16, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_INSERT, 64'h12AB_CDEF_0000_0000, 5'd2, 8'h07, 24'h1,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_NOT_CHEAPER);
        add_row(OP_INSERT, 64'h0000_0000_0000_0000, 5'd20, 8'h22, 24'h123,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h0000_0000_0000_0000, 5'd16, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h2000_0000_0000_0000, 5'd16, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 8'h00, 24'h0,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_INVALID);
        add_row(OP_INSERT, 64'h3333_3333_3333_333F, 5'd15, 8'h33, 24'h333,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_LOOKUP, 64'h3333_3333_3333_333A, 5'd15, 8'h00, 24'h0,
                0, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_DONE);
        add_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 8'hFF, 24'hFFFFFF,
                1, 0, 8'h00, 24'h0, 5'd0, ppt_pkg::ST_INVALID);

        send_idle_pct = 10;
        recv_idle_pct = 69;
        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].ans);
        end

        // Random traffic under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 10 : 0;
            repeat (RANDOM_ITEMS / 3) send_request(random_request(), 1'b0, no_ans);
        end
        req_if.valid <= 1'b0;

        // Drain, then watch for stray result words
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("[prefix_price_table] OK");
        end else begin
            $display("[prefix_price_table] ERROR");
        end
        $finish;
    end

endmodule
